// ----- rtl/mpdt_pkg.sv -----
// Shared constants, codes and divider handshake types for the peak demand tracker.
`timescale 1ns / 1ps
package mpdt_pkg;

  localparam int VAL_W  = 16;
  localparam int DAY_W  = 5;
  localparam int NUM_W  = 3;
  localparam int CNT_W  = 3;
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int STEP_W = 4;
  localparam int THR_W  = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MONTH  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_HOURS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HI     = 2'd2;

  localparam logic [NUM_W-1:0] PEAK_HOURS_RST = 3'd3;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/monthly_peak_demand_tracker_top.sv -----
// Top level of the monthly peak demand tracker: slot sequencer, step walk and ports.
//
// Input stream: s_axis carries one command per transfer (record an hourly peak,
// start a new month, or evaluate only). Each accepted item yields exactly one
// result transfer on m_axis with the averaged peak, the capacity step and the
// requested selected peak. Configuration writes use the cfg channel, which is
// always ready; write it only while the block is idle.
// One item at a time: s_axis_tready_o is low from acceptance until the result
// has moved into the output register. Processing walks the slot scans (one slot
// per cycle, one pass per averaged peak), the serial divide and the step walk;
// the block then returns to idle as the result is loaded and accepts the next item.
// The result waits in the output register while m_axis is stalled; the next
// item is accepted meanwhile, but its own result is held back until the
// previous one has been transferred.
// Reset empties all slots, clears the step pointer, sets the averaged peak
// count to 3 and all thresholds to 0.
`timescale 1ns / 1ps
module monthly_peak_demand_tracker_top #(
  parameter int PEAK_SLOTS = 5,
  parameter int STEP_LIMIT = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // hour_value[15:0], day_of_month[20:16], peak_number[23:21]
  input  logic [mpdt_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // command[1:0]
  input  logic [mpdt_pkg::CMD_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // peaks_changed[0], month_average[16:1], step_index[20:17],
  // current_threshold[28:21], selected_day[33:29], selected_value[49:34]
  output logic [mpdt_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mpdt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mpdt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mpdt_pkg::*;

  localparam int IDX_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
  localparam int ROUND_MAX = (PEAK_SLOTS < 7) ? PEAK_SLOTS : 7;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEAK_SLOTS - 1);
  localparam logic [STEP_W-1:0] PTR_MAX = STEP_W'((STEP_LIMIT < 15) ? STEP_LIMIT : 15);
  localparam logic [6:0] THR_SCALE = 7'd100;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_MIN, S_REPL, S_PSTART, S_PSCAN, S_DIV, S_STEP, S_SEL, S_OUT
  } state_e;

  state_e                  state_q;
  logic [NUM_W-1:0]        phu_q;
  logic [63:0]             thr_lo_q;
  logic [15:0]             thr_hi_q;

  logic [DAY_W-1:0]        slot_day_q [PEAK_SLOTS];
  logic [VAL_W-1:0]        slot_val_q [PEAK_SLOTS];
  logic [STEP_W-1:0]       step_ptr_q;

  logic [VAL_W-1:0]        val_q;
  logic [DAY_W-1:0]        day_q;
  logic [NUM_W-1:0]        num_q;
  logic [IDX_W-1:0]        idx_q;
  logic [IDX_W-1:0]        min_idx_q;
  logic [VAL_W-1:0]        least_q;
  logic                    found_q;
  logic                    changed_q;
  logic                    pass_q;
  logic [PEAK_SLOTS-1:0]   chosen_q;
  logic [NUM_W-1:0]        round_q;
  logic [VAL_W-1:0]        best_val_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [CNT_W-1:0]        count_q;
  logic [SUM_W-1:0]        sum_q;
  logic [VAL_W-1:0]        avg_q;
  logic [NUM_W-1:0]        pos_q;
  logic [DAY_W-1:0]        sel_day_q;
  logic [VAL_W-1:0]        sel_val_q;
  logic                    m_valid_q;
  logic [OUT_DATA_W-1:0]   m_data_q;
  div_req_t                div_req_q;
  div_rsp_t                div_rsp;

  logic                    s_acc;
  logic [NUM_W-1:0]        rounds;
  logic [DAY_W-1:0]        cur_day;
  logic [VAL_W-1:0]        cur_val;
  logic                    last;
  logic                    elig;
  logic [VAL_W-1:0]        nb_val;
  logic [IDX_W-1:0]        nb_idx;
  logic                    add_pick;
  logic [CNT_W-1:0]        count_nx;
  logic [SUM_W-1:0]        sum_nx;
  logic                    round_done;
  logic                    div_go;
  logic [THR_W-1:0]        cur_thr;
  logic [14:0]             thr100;
  logic                    query_ok;
  logic [NUM_W-1:0]        pos_nx;

  function automatic logic [THR_W-1:0] step_thr(input logic [STEP_W-1:0] ptr,
                                                input logic [63:0] lo,
                                                input logic [15:0] hi);
    logic [THR_W-1:0] thr;
    thr = '0;
    if (ptr < 4'd8) begin
      thr = lo[{ptr[2:0], 3'b000} +: THR_W];
    end else if (ptr < 4'd10) begin
      thr = hi[{ptr[0], 3'b000} +: THR_W];
    end
    return thr;
  endfunction

  mpdt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign rounds   = (int'(phu_q) > ROUND_MAX) ? NUM_W'(ROUND_MAX) : phu_q;
  assign cur_day  = slot_day_q[idx_q];
  assign cur_val  = slot_val_q[idx_q];
  assign last     = (idx_q == LAST_IDX);
  assign elig     = !chosen_q[idx_q] && !(!pass_q && (cur_day == '0)) && (cur_val > best_val_q);
  assign nb_val   = elig ? cur_val : best_val_q;
  assign nb_idx   = elig ? idx_q : best_idx_q;
  assign add_pick = (nb_val != '0);
  assign count_nx = count_q + CNT_W'(add_pick);
  assign sum_nx   = sum_q + (add_pick ? SUM_W'(nb_val) : '0);
  assign round_done = ((round_q + 1'b1) == rounds);
  assign div_go   = (state_q == S_PSCAN) && last && round_done && !pass_q && (count_nx != '0);
  assign cur_thr  = step_thr(step_ptr_q, thr_lo_q, thr_hi_q);
  assign thr100   = 15'(cur_thr) * 15'(THR_SCALE);
  assign query_ok = (num_q != '0) && (int'(num_q) <= PEAK_SLOTS);
  assign pos_nx   = pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phu_q    <= PEAK_HOURS_RST;
      thr_lo_q <= '0;
      thr_hi_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PEAK_HOURS: phu_q    <= cfg_data_i[NUM_W-1:0];
        CFG_THR_LO:     thr_lo_q <= cfg_data_i;
        CFG_THR_HI:     thr_hi_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      for (int i = 0; i < PEAK_SLOTS; i++) begin
        slot_day_q[i] <= '0;
        slot_val_q[i] <= '0;
      end
      step_ptr_q <= '0;
      val_q      <= '0;
      day_q      <= '0;
      num_q      <= '0;
      idx_q      <= '0;
      min_idx_q  <= '0;
      least_q    <= '0;
      found_q    <= 1'b0;
      changed_q  <= 1'b0;
      pass_q     <= 1'b0;
      chosen_q   <= '0;
      round_q    <= '0;
      best_val_q <= '0;
      best_idx_q <= '0;
      count_q    <= '0;
      sum_q      <= '0;
      avg_q      <= '0;
      pos_q      <= '0;
      sel_day_q  <= '0;
      sel_val_q  <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      div_req_q  <= '0;
    end else begin
      div_req_q.start <= div_go;
      if (m_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            val_q     <= s_axis_tdata_i[15:0];
            day_q     <= s_axis_tdata_i[20:16];
            num_q     <= s_axis_tdata_i[23:21];
            changed_q <= 1'b0;
            sel_day_q <= '0;
            sel_val_q <= '0;
            idx_q     <= '0;
            pass_q    <= 1'b0;
            case (s_axis_tuser_i)
              CMD_RECORD: state_q <= S_FIND;
              CMD_MONTH: begin
                for (int i = 0; i < PEAK_SLOTS; i++) begin
                  slot_day_q[i] <= '0;
                  slot_val_q[i] <= '0;
                end
                step_ptr_q <= '0;
                state_q    <= S_PSTART;
              end
              default: state_q <= S_PSTART;
            endcase
          end
        end
        S_FIND: begin
          if ((cur_day == day_q) || (cur_day == '0)) begin
            if (val_q > cur_val) begin
              slot_day_q[idx_q] <= day_q;
              slot_val_q[idx_q] <= val_q;
              changed_q         <= 1'b1;
            end
            state_q <= S_PSTART;
          end else if (last) begin
            idx_q   <= '0;
            least_q <= val_q;
            found_q <= 1'b0;
            state_q <= S_MIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_MIN: begin
          if (cur_val < least_q) begin
            least_q   <= cur_val;
            min_idx_q <= idx_q;
            found_q   <= 1'b1;
          end
          if (last) begin
            state_q <= S_REPL;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_REPL: begin
          if (found_q) begin
            slot_day_q[min_idx_q] <= day_q;
            slot_val_q[min_idx_q] <= val_q;
            changed_q             <= 1'b1;
          end
          state_q <= S_PSTART;
        end
        S_PSTART: begin
          chosen_q   <= '0;
          round_q    <= '0;
          best_val_q <= '0;
          best_idx_q <= '0;
          count_q    <= '0;
          sum_q      <= '0;
          idx_q      <= '0;
          pos_q      <= '0;
          if (rounds != '0) begin
            state_q <= S_PSCAN;
          end else if (pass_q) begin
            state_q <= S_SEL;
          end else begin
            avg_q   <= '0;
            state_q <= S_STEP;
          end
        end
        S_PSCAN: begin
          if (last) begin
            if (add_pick) begin
              chosen_q[nb_idx] <= 1'b1;
            end
            count_q    <= count_nx;
            sum_q      <= sum_nx;
            best_val_q <= '0;
            best_idx_q <= '0;
            idx_q      <= '0;
            round_q    <= round_q + 1'b1;
            if (round_done) begin
              if (pass_q) begin
                pos_q   <= '0;
                state_q <= S_SEL;
              end else if (count_nx == '0) begin
                avg_q   <= '0;
                state_q <= S_STEP;
              end else begin
                div_req_q.dividend <= sum_nx;
                div_req_q.divisor  <= count_nx;
                state_q            <= S_DIV;
              end
            end
          end else begin
            best_val_q <= nb_val;
            best_idx_q <= nb_idx;
            idx_q      <= idx_q + 1'b1;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            avg_q   <= div_rsp.quotient;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if ((step_ptr_q < PTR_MAX) && (avg_q > {1'b0, thr100})) begin
            step_ptr_q <= step_ptr_q + 1'b1;
          end else if (query_ok) begin
            pass_q  <= 1'b1;
            state_q <= S_PSTART;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_SEL: begin
          if (chosen_q[idx_q]) begin
            pos_q <= pos_nx;
          end
          if (chosen_q[idx_q] && (pos_nx == num_q)) begin
            sel_day_q <= cur_day;
            sel_val_q <= cur_val;
            state_q   <= S_OUT;
          end else if (last) begin
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'b0, sel_val_q, sel_day_q, cur_thr, step_ptr_q, avg_q, changed_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_month_clears_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (s_axis_tuser_i == CMD_MONTH)) |=> (step_ptr_q == '0))
    else $error("step pointer not cleared by month command");

  a_ptr_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_acc && (s_axis_tuser_i == CMD_MONTH)) |=> (step_ptr_q >= $past(step_ptr_q)))
    else $error("step pointer moved backward");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |=> (step_ptr_q <= PTR_MAX))
    else $error("step pointer beyond its limit");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide phase");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PSCAN) |-> (count_q <= rounds) && (round_q < rounds))
    else $error("peak count exceeds averaged peak number");

endmodule

// ----- rtl/mpdt_div.sv -----
// Bit-serial restoring divider for the peak sum over the peak count.
`timescale 1ns / 1ps
module mpdt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpdt_pkg::div_req_t req_i,
  output mpdt_pkg::div_rsp_t rsp_o
);
  import mpdt_pkg::*;

  localparam int BIT_W = $clog2(SUM_W);

  logic             busy_q;
  logic             done_q;
  logic [BIT_W-1:0] bit_q;
  logic [SUM_W-1:0] dvd_q;
  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] dvs_q;
  logic [CNT_W-1:0] rem_q;

  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [CNT_W-1:0] rem_d;

  assign rem_sh = {rem_q, dvd_q[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_d  = ge ? CNT_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        bit_q  <= BIT_W'(SUM_W - 1);
        dvd_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
        quo_q <= {quo_q[SUM_W-2:0], ge};
        bit_q <= bit_q - 1'b1;
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[VAL_W-1:0];

endmodule
